// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked every clock edge outside reset.
`define TLVS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must hold every clock edge outside reset.
`define TLVS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`else

`define TLVS_ASSERT(lbl, clk, rstn, prop, msg)
`define TLVS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/tlvs_pkg.sv =====
// ---------------------------------------------------------------------------
// tlvs_pkg
// Shared types and constants for the TLV type search block.
// ---------------------------------------------------------------------------
package tlvs_pkg;

  localparam int unsigned MAX_BUFFER_BYTES_DEF = 65536;

  // APB register map: one 32-bit register per word
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic        REG_SEARCH = 1'b0;  // word index of search_type

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_VALUE   = 2'd1,
    PH_MATCHED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_UNDERRUN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] match_len;
    logic [15:0] value_offset;
    logic [16:0] next_offset;
  } result_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } stage_t;

endpackage

// ===== rtl/tlv16_type_search.sv =====
// ---------------------------------------------------------------------------
// tlv16_type_search
// Streaming search of a type-length-value byte buffer for a given type.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one buffer byte per beat, last_byte set on the final byte.
//           Records are 16-bit big-endian type, 16-bit length, value bytes.
//   out_* : at most one result per buffer: found (length, value offset,
//           offset past the record) once the matching value has arrived,
//           not found at a clean end, underrun at a truncated end.
//           Bytes after a match give nothing until the buffer ends.
//   APB   : word 0 holds the searched type (low 16 bits), read back too.
//           Write it only while the block is idle.
// Timing: the input register and the result register lie between a byte
//   and its result. One byte per cycle is sustained while no result waits
//   on out_stall; the parse state update is the only loop.
// Stall: while out_stall holds a result, in_stall is high as soon as the
//   input register holds a byte, so at most one byte waits behind it.
//   Offsets clamp at MAX_BUFFER_BYTES; value_offset keeps only 16 bits.
//   Reset clears the parse state and the register to 0.
// ---------------------------------------------------------------------------
module tlv16_type_search #(
  parameter int unsigned MAX_BUFFER_BYTES = tlvs_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tlvs_pkg::beat_t               in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tlvs_pkg::result_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlvs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlvs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [15:0]      search_type;
  logic             advance;
  tlvs_pkg::stage_t stage;

  tlvs_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .search_type (search_type)
  );

  tlvs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  tlvs_parser #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .search_type (search_type),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/tlvs_apb_regs.sv =====
// ---------------------------------------------------------------------------
// tlvs_apb_regs
// APB register file holding the searched record type.
// ---------------------------------------------------------------------------
module tlvs_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlvs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlvs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlvs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [15:0]                   search_type
);

  logic [15:0] search_type_r;
  logic [15:0] search_type_nxt;
  logic        hit;

  assign pready = 1'b1;
  assign hit    = (paddr[tlvs_pkg::PADDR_W-1] == tlvs_pkg::REG_SEARCH);

  always_comb begin
    search_type_nxt = search_type_r;
    if (psel && penable && pwrite && hit) begin
      search_type_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_type_r <= '0;
    end else begin
      search_type_r <= search_type_nxt;
    end
  end

  assign prdata      = hit ? {{(tlvs_pkg::PDATA_W-16){1'b0}}, search_type_r} : '0;
  assign search_type = search_type_r;

endmodule

// ===== rtl/tlvs_in_stage.sv =====
// ---------------------------------------------------------------------------
// tlvs_in_stage
// Input register: captures one beat, holds it until the parser takes it.
// ---------------------------------------------------------------------------
module tlvs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tlvs_pkg::beat_t   in_data,
  input  logic              advance,
  output tlvs_pkg::stage_t  stage
);

  logic            valid_r;
  logic            valid_nxt;
  tlvs_pkg::beat_t beat_r;
  logic            load;

  // Full and the parser cannot move on this cycle
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.beat  = beat_r;

endmodule

// ===== rtl/tlvs_parser.sv =====
// ---------------------------------------------------------------------------
// tlvs_parser
// Record parse state, match check and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlvs_parser #(
  parameter int unsigned MAX_BUFFER_BYTES = tlvs_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlvs_pkg::stage_t  stage,
  input  logic [15:0]       search_type,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output tlvs_pkg::result_t out_data
);

  localparam int unsigned PW = $clog2(MAX_BUFFER_BYTES + 1);

  tlvs_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]        hcount_r, hcount_nxt;
  logic [15:0]       rtype_r, rtype_nxt;
  logic [15:0]       rlen_r, rlen_nxt;
  logic [15:0]       remain_r, remain_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [15:0]       vstart_r, vstart_nxt;

  logic              out_valid_r, out_valid_nxt;
  tlvs_pkg::result_t out_data_r, out_data_nxt;

  logic              fire;
  logic              complete;
  logic              produce;
  logic [PW-1:0]     pos_after;
  logic [PW+16:0]    pos_ext;
  logic [15:0]       remain_dec;

  // Output register frees up when empty or being taken this cycle
  assign advance = !out_valid_r || !out_stall;
  assign fire    = stage.valid && advance;

  assign pos_after  = (pos_r < PW'(MAX_BUFFER_BYTES)) ? pos_r + PW'(1) : pos_r;
  assign pos_ext    = {{17{1'b0}}, pos_after};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    rtype_nxt    = rtype_r;
    rlen_nxt     = rlen_r;
    remain_nxt   = remain_r;
    pos_nxt      = pos_r;
    vstart_nxt   = vstart_r;
    complete     = 1'b0;
    produce      = 1'b0;
    out_data_nxt = '{status: tlvs_pkg::ST_NOT_FOUND, match_len: '0,
                     value_offset: '0, next_offset: '0};

    if (fire) begin
      if (phase_r == tlvs_pkg::PH_MATCHED) begin
        // swallow the rest of the buffer
        if (stage.beat.last_byte) begin
          phase_nxt  = tlvs_pkg::PH_HEADER;
          hcount_nxt = '0;
          rtype_nxt  = '0;
          rlen_nxt   = '0;
          remain_nxt = '0;
          pos_nxt    = '0;
          vstart_nxt = '0;
        end
      end else begin
        pos_nxt = pos_after;
        if (phase_r == tlvs_pkg::PH_HEADER) begin
          case (hcount_r)
            2'd0:    rtype_nxt = {stage.beat.data_byte, 8'h00};
            2'd1:    rtype_nxt = {rtype_r[15:8], stage.beat.data_byte};
            2'd2:    rlen_nxt  = {stage.beat.data_byte, 8'h00};
            default: rlen_nxt  = {rlen_r[15:8], stage.beat.data_byte};
          endcase
          hcount_nxt = hcount_r + 2'd1;
          if (hcount_r == 2'd3) begin
            vstart_nxt = pos_ext[15:0];
            if (rlen_nxt == 16'd0) begin
              complete = 1'b1;
            end else begin
              remain_nxt = rlen_nxt;
              phase_nxt  = tlvs_pkg::PH_VALUE;
            end
          end
        end else begin
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0) begin
            complete  = 1'b1;
            phase_nxt = tlvs_pkg::PH_HEADER;
          end
        end

        if (complete && (rtype_nxt == search_type)) begin
          produce      = 1'b1;
          out_data_nxt = '{status: tlvs_pkg::ST_FOUND, match_len: rlen_nxt,
                           value_offset: vstart_nxt, next_offset: pos_ext[16:0]};
          phase_nxt    = tlvs_pkg::PH_MATCHED;
        end else if (stage.beat.last_byte) begin
          produce = 1'b1;
          if (phase_nxt == tlvs_pkg::PH_HEADER && hcount_nxt == 2'd0) begin
            out_data_nxt.status = tlvs_pkg::ST_NOT_FOUND;
          end else begin
            out_data_nxt.status = tlvs_pkg::ST_UNDERRUN;
          end
        end

        // end of buffer re-arms for the next one
        if (stage.beat.last_byte) begin
          phase_nxt  = tlvs_pkg::PH_HEADER;
          hcount_nxt = '0;
          rtype_nxt  = '0;
          rlen_nxt   = '0;
          remain_nxt = '0;
          pos_nxt    = '0;
          vstart_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tlvs_pkg::PH_HEADER;
      hcount_r    <= '0;
      rtype_r     <= '0;
      rlen_r      <= '0;
      remain_r    <= '0;
      pos_r       <= '0;
      vstart_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hcount_r    <= hcount_nxt;
      rtype_r     <= rtype_nxt;
      rlen_r      <= rlen_nxt;
      remain_r    <= remain_nxt;
      pos_r       <= pos_nxt;
      vstart_r    <= vstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TLVS_ASSERT_ALWAYS(a_value_nonzero, clk, rst_n,
    (phase_r != tlvs_pkg::PH_VALUE) || (remain_r != 16'd0), "value phase with nothing left")
  `TLVS_ASSERT_ALWAYS(a_hdr_aligned, clk, rst_n,
    (phase_r == tlvs_pkg::PH_HEADER) || (hcount_r == 2'd0), "header count off outside header")
  `TLVS_ASSERT(a_matched_silent, clk, rst_n,
    fire && (phase_r == tlvs_pkg::PH_MATCHED) |=> !out_valid_r, "result after match")
  `TLVS_ASSERT_ALWAYS(a_miss_zeroed, clk, rst_n,
    !out_valid_r || (out_data_r.status == tlvs_pkg::ST_FOUND) ||
    ((out_data_r.match_len == 16'd0) && (out_data_r.value_offset == 16'd0) &&
     (out_data_r.next_offset == 17'd0)), "miss result carries offsets")

endmodule
